### design/fwrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrc_pkg
// Shared types, constants and the rule match function of the rule classifier.
// ----------------------------------------------------------------------------
package fwrc_pkg;

    localparam int MAX_RULES = 64;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RULES);

    typedef enum logic [1:0] {
        SVC_TCP  = 2'd0,
        SVC_UDP  = 2'd1,
        SVC_ICMP = 2'd2,
        SVC_ANY  = 2'd3
    } t_svc;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_CHECK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_VERDICT = 2'd0,
        ST_STORED  = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // The first member sits in the highest bits, so the order is reversed
    // against the beat layout on the bus.
    typedef struct packed {
        logic        l4_dst_any;
        logic        l4_src_any;
        logic        dst_ip_any;
        logic        src_ip_any;
        logic [15:0] l4_dst;
        logic [15:0] l4_src;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic        rule_allow;
        t_svc        service;
        logic        direction;
    } t_pkt;

    localparam int PKT_W     = $bits(t_pkt);
    localparam int S_TDATA_W = ((PKT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;
    localparam int STATUS_W  = $bits(t_status);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic res_load;
    } t_fwrc_cmd;

    typedef struct packed {
        logic more;
        logic out_free;
    } t_fwrc_sts;

    function automatic logic rule_match(input t_pkt r, input t_pkt p);
        logic use_ports;
        logic base_ok;
        logic port_ok;
        use_ports = (p.service == SVC_TCP) || (p.service == SVC_UDP);
        base_ok   = (r.direction == p.direction)
                  && ((r.service == p.service) || (r.service == SVC_ANY))
                  && ((r.src_ip == p.src_ip) || r.src_ip_any)
                  && ((r.dst_ip == p.dst_ip) || r.dst_ip_any);
        port_ok   = ((r.l4_src == p.l4_src) || r.l4_src_any)
                  && ((r.l4_dst == p.l4_dst) || r.l4_dst_any);
        return base_ok && (!use_ports || port_ok);
    endfunction

endpackage

### design/fwrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrc_ctrl
// Sequencer: accepts a beat, steps the rule scan and hands the result over.
// ----------------------------------------------------------------------------
module fwrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    input  logic                i_s_axis_tuser,
    output logic                o_s_axis_tready,
    input  fwrc_pkg::t_fwrc_sts i_sts,
    output fwrc_pkg::t_fwrc_cmd o_cmd
);

    fwrc_pkg::t_state r_state;
    fwrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwrc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fwrc_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (fwrc_pkg::t_op'(i_s_axis_tuser) == fwrc_pkg::OP_CHECK) begin
                        n_state = fwrc_pkg::S_SCAN;
                    end else begin
                        n_state = fwrc_pkg::S_DONE;
                    end
                end
            end
            fwrc_pkg::S_SCAN: begin
                if (!i_sts.more) begin
                    n_state = fwrc_pkg::S_DONE;
                end
            end
            fwrc_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = fwrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwrc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            fwrc_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                o_cmd.load      = i_s_axis_tvalid;
            end
            fwrc_pkg::S_SCAN: begin
                o_cmd.rd_en = i_sts.more;
            end
            fwrc_pkg::S_DONE: begin
                o_cmd.res_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/fwrc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrc_dp
// Datapath: header register, rule memory, rule counter, match stage and the
// output register.
// ----------------------------------------------------------------------------
module fwrc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [fwrc_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [fwrc_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic [fwrc_pkg::STATUS_W-1:0]        o_m_axis_tuser,
    input  fwrc_pkg::t_fwrc_cmd                  i_cmd,
    output fwrc_pkg::t_fwrc_sts                  o_sts
);

    fwrc_pkg::t_pkt                  r_mem [fwrc_pkg::MAX_RULES];
    fwrc_pkg::t_pkt                  r_pkt;
    fwrc_pkg::t_op                   r_op;
    fwrc_pkg::t_pkt                  r_rd_rule;
    logic                            r_rd_vld;
    logic [fwrc_pkg::CNT_W-1:0]      r_count;
    logic [fwrc_pkg::CNT_W-1:0]      r_idx;
    logic                            r_verdict;
    logic                            r_m_valid;
    logic                            r_permit;
    fwrc_pkg::t_status               r_status;
    logic [fwrc_pkg::CNT_W-1:0]      n_count;
    logic                            n_permit;
    fwrc_pkg::t_status               n_status;
    logic                            full;
    logic                            wr_en;

    assign full  = (r_count == fwrc_pkg::CNT_MAX);
    assign wr_en = i_cmd.res_load && (r_op == fwrc_pkg::OP_APPEND) && !full;

    assign o_sts.more     = (r_idx < r_count) && (r_pkt.service != fwrc_pkg::SVC_ANY);
    assign o_sts.out_free = !r_m_valid || i_m_axis_tready;

    always_comb begin
        n_count = r_count;
        if (wr_en) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        n_permit = 1'b0;
        n_status = fwrc_pkg::ST_VERDICT;
        if (r_op == fwrc_pkg::OP_CHECK) begin
            n_permit = r_verdict;
        end else if (full) begin
            n_status = fwrc_pkg::ST_FULL;
        end else begin
            n_status = fwrc_pkg::ST_STORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[fwrc_pkg::IDX_W-1:0]] <= r_pkt;
        end
        if (i_cmd.rd_en) begin
            r_rd_rule <= r_mem[r_idx[fwrc_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pkt     <= fwrc_pkg::t_pkt'(i_s_axis_tdata[fwrc_pkg::PKT_W-1:0]);
            r_op      <= fwrc_pkg::t_op'(i_s_axis_tuser);
            r_verdict <= i_s_axis_tdata[0];
        end else if (r_rd_vld && fwrc_pkg::rule_match(r_rd_rule, r_pkt)) begin
            r_verdict <= r_rd_rule.rule_allow;
        end
        if (i_cmd.res_load) begin
            r_permit <= n_permit;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.res_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(fwrc_pkg::M_TDATA_W-1){1'b0}}, r_permit};
    assign o_m_axis_tuser  = r_status;

endmodule

### design/firewall_rule_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firewall_rule_classifier
// Ordered packet filter rule table with last-match-wins header checks.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one item. tuser selects append rule (0) or
// check header (1); tdata carries the header or rule fields. Each item gives
// exactly one output beat: tdata bit 0 is the verdict (1 allow) and tuser is
// the status (0 verdict, 1 rule stored, 2 table full and rule dropped).
// An append goes from acceptance through the done step to the output
// register. A check walks the stored rules one per cycle through the single
// read port of the rule memory (up to 64 rules with a full table); a check
// of an unknown service skips the walk.
// One item is in work at a time; the input is ready again once the result
// sits in the output register, even while the receiver still stalls it, so
// a new beat is taken only after the last item's result is registered.
// While the receiver holds tready low, the finished result waits in the
// output register and the next item waits in the done step.
// A synchronous reset empties the rule table and drops any pending result.
// ----------------------------------------------------------------------------
module firewall_rule_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // direction, service, rule_allow, src_ip, dst_ip, l4_src, l4_dst,
    // src_ip_any, dst_ip_any, l4_src_any, l4_dst_any
    input  logic [fwrc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // opcode
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // permit
    output logic [fwrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [fwrc_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    fwrc_pkg::t_fwrc_cmd cmd;
    fwrc_pkg::t_fwrc_sts sts;

    fwrc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    fwrc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

### design/fwrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrc_port_props
// Port-level checks of the rule classifier, bound to the top level.
// ----------------------------------------------------------------------------
module fwrc_port_props (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [fwrc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input logic                             i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [fwrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [fwrc_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // One item at a time: an accepted beat closes the input in the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted twice in a row");

    // Only checks may report an allow verdict.
    a_permit_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != fwrc_pkg::ST_VERDICT)
        |-> (o_m_axis_tdata == '0))
        else $error("append result carries a verdict");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == fwrc_pkg::ST_VERDICT)
                         || (o_m_axis_tuser == fwrc_pkg::ST_STORED)
                         || (o_m_axis_tuser == fwrc_pkg::ST_FULL))
        else $error("unknown status code");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind firewall_rule_classifier fwrc_port_props u_fwrc_port_props (.*);

### dv/fwrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrc_checker
// Watches both stream channels of the rule classifier and predicts its output.
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a local copy of the rule table
// to build the expected output beat. Each accepted output beat is compared
// field by field with the oldest expected beat. The failure count, the
// number of expected beats still outstanding and the number of checks
// decided by a stored rule go back to the testbench top.
// ----------------------------------------------------------------------------
module fwrc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [fwrc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [fwrc_pkg::M_TDATA_W-1:0]   i_m_tdata,
    input  logic [fwrc_pkg::STATUS_W-1:0]    i_m_tuser,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_rule_hits
);

    typedef struct packed {
        logic              permit;
        fwrc_pkg::t_status status;
    } t_verdict;

    fwrc_pkg::t_pkt rule_table [fwrc_pkg::MAX_RULES];
    int             rule_total;
    t_verdict       verdict_queue [$];
    t_verdict       oldest;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic t_verdict expected_verdict(input fwrc_pkg::t_op op,
                                                  input fwrc_pkg::t_pkt item);
        t_verdict       res;
        fwrc_pkg::t_pkt r;
        logic           ports_used;
        logic           decided;
        int             k;
        res.permit = 1'b0;
        res.status = fwrc_pkg::ST_VERDICT;
        decided    = 1'b0;
        if (op == fwrc_pkg::OP_APPEND) begin
            if (rule_total >= fwrc_pkg::MAX_RULES) begin
                res.status = fwrc_pkg::ST_FULL;
            end else begin
                rule_table[rule_total] = item;
                rule_total++;
                res.status = fwrc_pkg::ST_STORED;
            end
            return res;
        end
        // Inbound traffic is denied and outbound allowed unless a rule decides.
        res.permit = item.direction;
        if (item.service == fwrc_pkg::SVC_ANY) begin
            return res;
        end
        ports_used = (item.service == fwrc_pkg::SVC_TCP)
                  || (item.service == fwrc_pkg::SVC_UDP);
        for (k = 0; k < rule_total; k++) begin
            r = rule_table[k];
            if (r.direction == item.direction
                && (r.service == item.service || r.service == fwrc_pkg::SVC_ANY)
                && (r.src_ip_any || r.src_ip == item.src_ip)
                && (r.dst_ip_any || r.dst_ip == item.dst_ip)
                && (!ports_used
                    || ((r.l4_src_any || r.l4_src == item.l4_src)
                        && (r.l4_dst_any || r.l4_dst == item.l4_dst)))) begin
                res.permit = r.rule_allow;
                decided    = 1'b1;
            end
        end
        if (decided) begin
            o_rule_hits++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rule_total = 0;
            verdict_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_queue.size() == 0) begin
                    report_mismatch("unexpected output beat, status", i_m_tuser, 0);
                end else begin
                    oldest = verdict_queue.pop_front();
                    if (i_m_tdata[0] !== oldest.permit) begin
                        report_mismatch("permit", i_m_tdata[0], oldest.permit);
                    end
                    if (i_m_tuser !== oldest.status) begin
                        report_mismatch("status", i_m_tuser, oldest.status);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                verdict_queue.push_back(expected_verdict(
                    fwrc_pkg::t_op'(i_s_tuser),
                    fwrc_pkg::t_pkt'(i_s_tdata[fwrc_pkg::PKT_W-1:0])));
            end
        end
        o_pending = verdict_queue.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the firewall rule classifier.
// ----------------------------------------------------------------------------
// A directed run covers the empty table, every service, wildcards, ignored
// ports on icmp, the unknown service and last-match ordering. Random items
// follow: rules from a small pool of addresses and ports so that several
// rules overlap, header checks built from stored rules with occasional
// changes, and plain noise. The table fills early, so many appends are
// dropped. Both sides stall at random at two loads; a last phase has none.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 1930;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [fwrc_pkg::S_TDATA_W-1:0] i_s_axis_tdata;
    logic                           i_s_axis_tuser;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [fwrc_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic [fwrc_pkg::STATUS_W-1:0]  o_m_axis_tuser;

    int fail_count;
    int pending;
    int rule_hits;

    int             tx_idle_pct;
    int             rx_idle_pct;
    fwrc_pkg::t_pkt rule_copy [$];
    int             appends_sent;
    int             appends_dropped;
    int             checks_sent;
    logic [31:0]    ip_pool [4];
    logic [15:0]    port_pool [4];

    firewall_rule_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    fwrc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_rule_hits  (rule_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic fwrc_pkg::t_pkt make_item(input logic dir, input fwrc_pkg::t_svc svc,
                                                 input logic allow,
                                                 input logic [31:0] sip,
                                                 input logic [31:0] dip,
                                                 input logic [15:0] sport,
                                                 input logic [15:0] dport,
                                                 input logic [3:0] wild);
        fwrc_pkg::t_pkt p;
        p.direction  = dir;
        p.service    = svc;
        p.rule_allow = allow;
        p.src_ip     = sip;
        p.dst_ip     = dip;
        p.l4_src     = sport;
        p.l4_dst     = dport;
        p.src_ip_any = wild[0];
        p.dst_ip_any = wild[1];
        p.l4_src_any = wild[2];
        p.l4_dst_any = wild[3];
        return p;
    endfunction

    function automatic fwrc_pkg::t_pkt random_noise();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[fwrc_pkg::PKT_W-1:0];
    endfunction

    function automatic logic [31:0] pick_ip();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            4: return $urandom;
            default: return ip_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            4: return 16'($urandom);
            default: return port_pool[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic fwrc_pkg::t_pkt random_rule();
        fwrc_pkg::t_pkt r;
        r = random_noise();
        r.src_ip     = pick_ip();
        r.dst_ip     = pick_ip();
        r.l4_src     = pick_port();
        r.l4_dst     = pick_port();
        r.src_ip_any = ($urandom_range(0, 3) == 0);
        r.dst_ip_any = ($urandom_range(0, 3) == 0);
        r.l4_src_any = ($urandom_range(0, 3) == 0);
        r.l4_dst_any = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    function automatic fwrc_pkg::t_pkt header_near(input fwrc_pkg::t_pkt r);
        fwrc_pkg::t_pkt h;
        int             b;
        h = random_noise();
        h.direction = r.direction;
        h.service   = (r.service == fwrc_pkg::SVC_ANY)
                    ? fwrc_pkg::t_svc'($urandom_range(0, 2)) : r.service;
        h.src_ip    = r.src_ip_any ? pick_ip() : r.src_ip;
        h.dst_ip    = r.dst_ip_any ? pick_ip() : r.dst_ip;
        h.l4_src    = r.l4_src_any ? pick_port() : r.l4_src;
        h.l4_dst    = r.l4_dst_any ? pick_port() : r.l4_dst;
        b = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0: h.src_ip[2 * b] = ~h.src_ip[2 * b];
            1: h.dst_ip = pick_ip();
            2: h.l4_src = pick_port();
            3: h.l4_dst[b] = ~h.l4_dst[b];
            4: h.direction = ~h.direction;
            5: h.service = fwrc_pkg::SVC_ANY;
            default: ;
        endcase
        return h;
    endfunction

    task automatic send_item(input fwrc_pkg::t_op op, input fwrc_pkg::t_pkt item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= item;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (op == fwrc_pkg::OP_APPEND) begin
            appends_sent++;
            if (rule_copy.size() < fwrc_pkg::MAX_RULES) begin
                rule_copy.push_back(item);
            end else begin
                appends_dropped++;
            end
        end else begin
            checks_sent++;
        end
    endtask

    initial begin
        int             pick;
        int             n;
        fwrc_pkg::t_pkt item;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        tx_idle_pct     = 21;
        rx_idle_pct     = 48;
        appends_sent    = 0;
        appends_dropped = 0;
        checks_sent     = 0;
        for (n = 0; n < 4; n++) begin
            ip_pool[n]   = $urandom;
            port_pool[n] = 16'($urandom);
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b1,
                  32'h0, 32'h0, 16'h0, 16'h0, 4'hF));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b1, fwrc_pkg::SVC_ICMP, 1'b0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_APPEND, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b1,
                  32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b0,
                  32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b0,
                  32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFE, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_UDP, 1'b0,
                  32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'h0));
        send_item(fwrc_pkg::OP_APPEND, make_item(1'b0, fwrc_pkg::SVC_ICMP, 1'b1,
                  32'hC0A8_0001, 32'h0A00_0001, 16'h1234, 16'h5678, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_ICMP, 1'b0,
                  32'hC0A8_0001, 32'h0A00_0001, 16'hFFFF, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_APPEND, make_item(1'b1, fwrc_pkg::SVC_ANY, 1'b0,
                  32'h0, 32'h0, 16'h0, 16'h0, 4'hF));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b1, fwrc_pkg::SVC_UDP, 1'b1,
                  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'hF));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b1, fwrc_pkg::SVC_ANY, 1'b1,
                  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_APPEND, make_item(1'b1, fwrc_pkg::SVC_UDP, 1'b1,
                  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b1, fwrc_pkg::SVC_UDP, 1'b0,
                  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b1, fwrc_pkg::SVC_TCP, 1'b0,
                  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_APPEND, make_item(1'b0, fwrc_pkg::SVC_ANY, 1'b0,
                  32'h0, 32'h0, 16'h0, 16'h0, 4'h3));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0, 4'h0));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_ICMP, 1'b0,
                  32'hC0A8_0001, 32'h0A00_0001, 16'h1, 16'h1, 4'h0));
        send_item(fwrc_pkg::OP_APPEND, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b1,
                  32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 4'hC));
        send_item(fwrc_pkg::OP_CHECK, make_item(1'b0, fwrc_pkg::SVC_TCP, 1'b0,
                  32'h0, 32'h0, 16'h7, 16'h9, 4'h0));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 48;
                rx_idle_pct = 21;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_item(fwrc_pkg::OP_APPEND, random_rule());
            end else if (pick < 20) begin
                send_item(fwrc_pkg::t_op'($urandom_range(0, 1)), random_noise());
            end else if (pick < 28 || rule_copy.size() == 0) begin
                item = random_rule();
                send_item(fwrc_pkg::OP_CHECK, item);
            end else begin
                item = header_near(rule_copy[$urandom_range(0, rule_copy.size() - 1)]);
                send_item(fwrc_pkg::OP_CHECK, item);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);

        $display("Sent %0d rule appends (%0d dropped on a full table) and %0d header checks.",
                 appends_sent, appends_dropped, checks_sent);
        $display("%0d checks were decided by a stored rule; %0d mismatches.",
                 rule_hits, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
design/fwrc_pkg.sv
design/fwrc_ctrl.sv
design/fwrc_dp.sv
design/firewall_rule_classifier.sv
design/fwrc_checker.sv
dv/fwrc_checker.sv
dv/tb.sv
